// ----- src/ncd_pkg.sv -----
// Shared constants, widths and codes for the nearest-centroid distance block.
// No dependencies; imported by every module of the block but ncd_ram.
package ncd_pkg;

    localparam int MAX_CLUSTERS = 16;
    localparam int MAX_FEATURES = 32;
    localparam int VALUE_WIDTH  = 16;

    localparam int CL_W   = $clog2(MAX_CLUSTERS);
    localparam int FI_W   = $clog2(MAX_FEATURES);
    localparam int ADDR_W = CL_W + FI_W;
    localparam int DEPTH  = MAX_CLUSTERS * MAX_FEATURES;

    localparam int CC_W  = 5;
    localparam int FC_W  = 6;
    localparam int CFG_W = 6;

    localparam int MAG_W  = VALUE_WIDTH;
    localparam int SQ_W   = 2 * MAG_W;
    localparam int DIST_W = 37;
    localparam int ROOT_W = 19;

    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    typedef enum logic [0:0] {
        OP_CENTROID = 1'b0,
        OP_QUERY    = 1'b1
    } t_opcode;

    typedef enum logic [0:0] {
        CFG_CLUSTERS = 1'b0,
        CFG_FEATURES = 1'b1
    } t_cfg_index;

    typedef enum logic [3:0] {
        S_IDLE      = 4'b0001,
        S_RUN       = 4'b0010,
        S_ROOT_GO   = 4'b0100,
        S_ROOT_WAIT = 4'b1000
    } t_state;

endpackage

// ----- src/ncd_ram.sv -----
// Generic simple dual-port synchronous RAM, one write and one registered read port.
// No dependencies.
module ncd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/ncd_isqrt.sv -----
// Iterative floor square root, one result bit per cycle.
// Depends on ncd_pkg.
module ncd_isqrt
    import ncd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DIST_W-1:0] i_operand,
    output logic              o_done,
    output logic [ROOT_W-1:0] o_root
);

    localparam int X_W   = 2 * ROOT_W;
    localparam int REM_W = ROOT_W + 2;
    localparam int SH_W  = ROOT_W + 4;
    localparam int CNT_W = $clog2(ROOT_W + 1);

    logic [X_W-1:0]    r_x;
    logic [REM_W-1:0]  r_rem;
    logic [ROOT_W-1:0] r_root;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_done;

    logic [SH_W-1:0] rem_sh;
    logic [SH_W-1:0] trial;
    logic [SH_W-1:0] diff;
    logic            fits;

    assign rem_sh = {r_rem, r_x[X_W-1 -: 2]};
    assign trial  = {2'b00, r_root, 2'b01};
    assign diff   = rem_sh - trial;
    assign fits   = (rem_sh >= trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= CNT_W'(ROOT_W);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x    <= X_W'(i_operand);
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_cnt != '0) begin
            r_x <= {r_x[X_W-3:0], 2'b00};
            if (fits) begin
                r_rem  <= diff[REM_W-1:0];
                r_root <= {r_root[ROOT_W-2:0], 1'b1};
            end else begin
                r_rem  <= rem_sh[REM_W-1:0];
                r_root <= {r_root[ROOT_W-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

// ----- src/ncd_core.sv -----
// Control, configuration and accumulate pipeline around the centroid and sum memories.
// Depends on ncd_pkg and ncd_ram.
module ncd_core
    import ncd_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    output logic                          o_busy,
    input  logic                          i_opcode,
    input  logic [CL_W-1:0]               i_cluster_index,
    input  logic [FI_W-1:0]               i_feature_index,
    input  logic signed [VALUE_WIDTH-1:0] i_value,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_index,
    input  logic [CFG_W-1:0]              i_cfg_wdata,
    output logic                          o_root_start,
    output logic [DIST_W-1:0]             o_root_operand,
    input  logic                          i_root_done,
    input  logic [ROOT_W-1:0]             i_root_value,
    output logic                          o_valid,
    output logic [DIST_W-1:0]             o_distance_squared,
    output logic [ROOT_W-1:0]             o_distance_root
);

    localparam logic [CL_W-1:0] K_LAST = CL_W'(MAX_CLUSTERS - 1);

    t_state r_state, n_state;

    logic [CC_W-1:0] r_cluster_count;
    logic [FC_W-1:0] r_feature_count;
    logic [CL_W-1:0] used_cl_m1;
    logic [FI_W-1:0] used_fe_m1;

    logic                   r_sums_valid;
    logic [FI_W-1:0]        r_fi;
    logic [VALUE_WIDTH-1:0] r_val;
    logic                   r_clear;
    logic                   r_last;

    logic            r_issuing;
    logic [CL_W-1:0] r_issue_k;

    logic              r_s1_vld;
    logic [CL_W-1:0]   r_s1_k;
    logic              r_s2_vld;
    logic [CL_W-1:0]   r_s2_k;
    logic [MAG_W-1:0]  r_s2_mag;
    logic [DIST_W-1:0] r_s2_sum;
    logic              r_s3_vld;
    logic [CL_W-1:0]   r_s3_k;
    logic [SQ_W-1:0]   r_s3_sq;
    logic [DIST_W-1:0] r_s3_sum;

    logic [DIST_W-1:0] r_min;
    logic              r_out_vld;
    logic [DIST_W-1:0] r_out_dist;
    logic [ROOT_W-1:0] r_out_root;

    logic accept, cen_we, qry_go, pass_end;

    logic [VALUE_WIDTH-1:0] cen_rdata;
    logic [DIST_W-1:0]      sum_rdata;
    logic [VALUE_WIDTH:0]   diff, diff_neg;
    logic [MAG_W-1:0]       mag;
    logic [DIST_W:0]        total;
    logic [DIST_W-1:0]      new_sum;
    logic                   k_used;

    assign accept   = i_start && (r_state == S_IDLE);
    assign cen_we   = accept && (i_opcode == OP_CENTROID);
    assign qry_go   = accept && (i_opcode == OP_QUERY);
    assign pass_end = r_s3_vld && (r_s3_k == K_LAST);

    always_comb begin
        if (r_cluster_count == '0) begin
            used_cl_m1 = '0;
        end else if (r_cluster_count > CC_W'(MAX_CLUSTERS)) begin
            used_cl_m1 = K_LAST;
        end else begin
            used_cl_m1 = CL_W'(r_cluster_count - 1'b1);
        end
        if (r_feature_count == '0) begin
            used_fe_m1 = '0;
        end else if (r_feature_count > FC_W'(MAX_FEATURES)) begin
            used_fe_m1 = FI_W'(MAX_FEATURES - 1);
        end else begin
            used_fe_m1 = FI_W'(r_feature_count - 1'b1);
        end
    end

    ncd_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (DEPTH)
    ) u_centroid_ram (
        .i_clk   (i_clk),
        .i_we    (cen_we),
        .i_waddr ({i_cluster_index, i_feature_index}),
        .i_wdata (i_value),
        .i_raddr ({r_issue_k, r_fi}),
        .o_rdata (cen_rdata)
    );

    ncd_ram #(
        .WIDTH (DIST_W),
        .DEPTH (MAX_CLUSTERS)
    ) u_sum_ram (
        .i_clk   (i_clk),
        .i_we    (r_s3_vld),
        .i_waddr (r_s3_k),
        .i_wdata (new_sum),
        .i_raddr (r_issue_k),
        .o_rdata (sum_rdata)
    );

    assign diff     = {cen_rdata[VALUE_WIDTH-1], cen_rdata} - {r_val[VALUE_WIDTH-1], r_val};
    assign diff_neg = (~diff) + 1'b1;
    assign mag      = diff[VALUE_WIDTH] ? diff_neg[MAG_W-1:0] : diff[MAG_W-1:0];

    assign total   = {1'b0, r_s3_sum} + (DIST_W + 1)'(r_s3_sq);
    assign new_sum = total[DIST_W] ? DIST_MAX : total[DIST_W-1:0];
    assign k_used  = (r_s3_k <= used_cl_m1);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (qry_go) begin
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (pass_end) begin
                    n_state = r_last ? S_ROOT_GO : S_IDLE;
                end
            end
            S_ROOT_GO: begin
                n_state = S_ROOT_WAIT;
            end
            S_ROOT_WAIT: begin
                if (i_root_done) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_cluster_count <= CC_W'(1);
            r_feature_count <= FC_W'(1);
            r_sums_valid    <= 1'b0;
            r_issuing       <= 1'b0;
            r_issue_k       <= '0;
            r_s1_vld        <= 1'b0;
            r_s2_vld        <= 1'b0;
            r_s3_vld        <= 1'b0;
            r_out_vld       <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_s1_vld  <= r_issuing;
            r_s2_vld  <= r_s1_vld;
            r_s3_vld  <= r_s2_vld;
            r_out_vld <= (r_state == S_ROOT_WAIT) && i_root_done;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_CLUSTERS: r_cluster_count <= i_cfg_wdata[CC_W-1:0];
                    CFG_FEATURES: r_feature_count <= i_cfg_wdata[FC_W-1:0];
                endcase
            end
            if (qry_go) begin
                r_issuing <= 1'b1;
                r_issue_k <= '0;
            end else if (r_issuing) begin
                r_issue_k <= r_issue_k + 1'b1;
                if (r_issue_k == K_LAST) begin
                    r_issuing <= 1'b0;
                end
            end
            if (pass_end) begin
                r_sums_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (qry_go) begin
            r_fi    <= i_feature_index;
            r_val   <= i_value;
            r_clear <= (i_feature_index == '0) || !r_sums_valid;
            r_last  <= (i_feature_index == used_fe_m1);
        end
        r_s1_k   <= r_issue_k;
        r_s2_k   <= r_s1_k;
        r_s2_mag <= mag;
        r_s2_sum <= r_clear ? '0 : sum_rdata;
        r_s3_k   <= r_s2_k;
        r_s3_sq  <= r_s2_mag * r_s2_mag;
        r_s3_sum <= r_s2_sum;
        if (r_s3_vld) begin
            if (r_s3_k == '0) begin
                r_min <= new_sum;
            end else if (k_used && (new_sum < r_min)) begin
                r_min <= new_sum;
            end
        end
        if ((r_state == S_ROOT_WAIT) && i_root_done) begin
            r_out_dist <= r_min;
            r_out_root <= i_root_value;
        end
    end

    assign o_busy             = (r_state != S_IDLE);
    assign o_root_start       = (r_state == S_ROOT_GO);
    assign o_root_operand     = r_min;
    assign o_valid            = r_out_vld;
    assign o_distance_squared = r_out_dist;
    assign o_distance_root    = r_out_root;

endmodule

// ----- src/nearest_centroid_distance_top.sv -----
// Top level of the nearest-centroid distance scorer.
// Depends on ncd_pkg, ncd_core (with ncd_ram) and ncd_isqrt.
//
// Usage:
//   Command channel: an item is taken at a rising edge with start high and
//   busy low. Opcode centroid writes i_value into the centroid memory at
//   (i_cluster_index, i_feature_index) and does not raise busy: busy stays
//   low. Opcode query streams one feature of a vector, in index order; feature
//   zero restarts the per-cluster sums.
//   Each query feature walks all MAX_CLUSTERS sums through one shared
//   subtract-square-accumulate pipeline, one cluster per cycle, reading and
//   writing back the sum memory, with busy high until the pass ends.
//   On the feature equal to feature_count - 1 the running minimum goes into
//   the bit-serial square root unit, which keeps busy high until the root is
//   done; o_valid then pulses for one cycle, the first with busy low, with
//   o_distance_squared and o_distance_root.
//   The result must be taken in that cycle; the receiver cannot stall.
//   Configuration: i_cfg_we with i_cfg_index 0 (cluster count) or 1 (feature
//   count), written by the user only while busy is low; the block does not enforce it.
//   Counts are clamped to 1..max. Reset: counts return to one, sums read as zero,
//   centroid contents are undefined until written. No clearing pass is needed.
module nearest_centroid_distance_top
    import ncd_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_opcode,
    input  logic [CL_W-1:0]               i_cluster_index,
    input  logic [FI_W-1:0]               i_feature_index,
    input  logic signed [VALUE_WIDTH-1:0] i_value,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_index,
    input  logic [CFG_W-1:0]              i_cfg_wdata,
    output logic                          o_valid,
    output logic [DIST_W-1:0]             o_distance_squared,
    output logic [ROOT_W-1:0]             o_distance_root
);

    logic              root_start;
    logic [DIST_W-1:0] root_operand;
    logic              root_done;
    logic [ROOT_W-1:0] root_value;

    ncd_core u_core (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_start            (start),
        .o_busy             (busy),
        .i_opcode           (i_opcode),
        .i_cluster_index    (i_cluster_index),
        .i_feature_index    (i_feature_index),
        .i_value            (i_value),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_wdata        (i_cfg_wdata),
        .o_root_start       (root_start),
        .o_root_operand     (root_operand),
        .i_root_done        (root_done),
        .i_root_value       (root_value),
        .o_valid            (o_valid),
        .o_distance_squared (o_distance_squared),
        .o_distance_root    (o_distance_root)
    );

    ncd_isqrt u_isqrt (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (root_start),
        .i_operand (root_operand),
        .o_done    (root_done),
        .o_root    (root_value)
    );

endmodule

// ----- src/ncd_checker.sv -----
// Port-level checks for the nearest-centroid distance top level, with its bind.
// Depends on ncd_pkg.
module ncd_checker
    import ncd_pkg::*;
(
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          start,
    input logic                          busy,
    input logic                          i_opcode,
    input logic                          o_valid,
    input logic [DIST_W-1:0]             o_distance_squared,
    input logic [ROOT_W-1:0]             o_distance_root
);

    localparam int CW = 2 * ROOT_W + 2;

    logic [CW-1:0] root_x, root_p1, dist_x;

    assign root_x  = CW'(o_distance_root);
    assign root_p1 = root_x + 1'b1;
    assign dist_x  = CW'(o_distance_squared);

    a_valid_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("result without a pending query");

    a_valid_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    a_write_no_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_opcode == OP_CENTROID)) |=> !busy)
        else $error("centroid write raised busy");

    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_opcode == OP_QUERY)) |=> busy)
        else $error("query item did not raise busy");

    a_root_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((root_x * root_x <= dist_x) && (root_p1 * root_p1 > dist_x)))
        else $error("root is not the floor square root of the distance");

endmodule

bind nearest_centroid_distance_top ncd_checker u_ncd_checker (.*);
